// ===== rtl/sorted_sparse_row_store_assert.svh =====
// Assertion macros used by the sorted sparse row store datapath.
`ifndef SORTED_SPARSE_ROW_STORE_ASSERT_SVH
`define SORTED_SPARSE_ROW_STORE_ASSERT_SVH

// Invariant that must hold at every clock edge outside reset.
`define SSRS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define SSRS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SSRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ssrs_pkg.sv =====
// Package: constants, codes and shared structs of the sorted sparse row store.
`timescale 1ns / 1ps
package ssrs_pkg;

    // Table geometry
    localparam int CAPACITY    = 1024;
    localparam int COLUMN_BITS = 24;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // Field widths
    localparam int KEY_W     = 24;
    localparam int COEF_W    = 64;
    localparam int COL_OUT_W = 25;
    localparam int STATUS_W  = 3;

    // Stream widths
    localparam int S_TDATA_W = KEY_W + COEF_W;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = ((COEF_W + COL_OUT_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 1 + STATUS_W;

    typedef enum logic [1:0] {
        MODE_INSERT   = 2'd0,
        MODE_LOOKUP   = 2'd1,
        MODE_POSITION = 2'd2,
        MODE_EXISTS   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_ZERO      = 3'd2,
        ST_FULL      = 3'd3,
        ST_QUERY     = 3'd4
    } t_status;

    // Which result the datapath builds
    typedef enum logic [2:0] {
        RES_INSERTED,
        RES_DUPLICATE,
        RES_ZERO,
        RES_FULL,
        RES_LOOKUP,
        RES_EXISTS,
        RES_POSITION,
        RES_OUT_OF_RANGE
    } t_res_kind;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        logic      search_init;
        logic      from_cursor;
        logic      search_step;
        logic      cursor_upd;
        logic      shift_init;
        logic      shift_step;
        logic      write_new;
        logic      rd_key;
        logic      set_res;
        t_res_kind res_kind;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic zero_coef;
        logic key_in_range;
        logic table_full;
        logic stop;
        logic eq;
        logic scan_end;
        logic shift_done;
    } t_dp_stat;

    typedef struct packed {
        logic [COEF_W-1:0]           value_out;
        logic signed [COL_OUT_W-1:0] column_out;
        logic                        found;
        t_status                     status;
    } t_result;

endpackage

// ===== rtl/ssrs_dp.sv =====
// Datapath: column and coefficient memories, count, cursor, scan and shift pipeline.
`timescale 1ns / 1ps
module ssrs_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ssrs_pkg::KEY_W-1:0]  i_key,
    input  logic [ssrs_pkg::COEF_W-1:0] i_coef,
    input  ssrs_pkg::t_ctrl_cmd        i_cmd,
    output ssrs_pkg::t_dp_stat         o_stat,
    output ssrs_pkg::t_result          o_result
);
    import ssrs_pkg::*;

    // Memories (contents undefined until written)
    logic [COLUMN_BITS-1:0] r_col_mem  [CAPACITY];
    logic [COEF_W-1:0]      r_coef_mem [CAPACITY];

    // Control state
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_cursor, n_cursor;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic             r_q_vld, n_q_vld;

    // Payload
    logic [KEY_W-1:0]       r_key;
    logic [COEF_W-1:0]      r_coef;
    logic [COLUMN_BITS-1:0] r_col_q;
    logic [COEF_W-1:0]      r_coef_q;
    logic [CNT_W-1:0]       r_q_idx;
    t_result                r_res, n_res;

    logic [COLUMN_BITS-1:0] w_key_col;
    logic                   w_stop, w_eq;
    logic [CNT_W-1:0]       w_idx_inc, w_idx_dec, w_q_inc;
    logic                   w_rd_en;
    logic [CNT_W-1:0]       w_rd_idx;
    logic [ADDR_W-1:0]      w_rd_addr;
    logic                   w_we;
    logic [ADDR_W-1:0]      w_wa;
    logic [COLUMN_BITS-1:0] w_wcol;
    logic [COEF_W-1:0]      w_wcoef;
    logic                   w_full;

    assign w_key_col = r_key[COLUMN_BITS-1:0];
    assign w_stop    = r_q_vld && (r_col_q >= w_key_col);
    assign w_eq      = r_q_vld && (r_col_q == w_key_col);
    assign w_idx_inc = r_idx + 1'b1;
    assign w_idx_dec = r_idx - 1'b1;
    assign w_q_inc   = r_q_idx + 1'b1;
    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_rd_addr = w_rd_idx[ADDR_W-1:0];

    // Status toward the controller
    assign o_stat.zero_coef    = (r_coef[COEF_W-2:0] == '0);
    assign o_stat.key_in_range = (r_key < {{(KEY_W-CNT_W){1'b0}}, r_count});
    assign o_stat.table_full   = w_full;
    assign o_stat.stop         = w_stop;
    assign o_stat.eq           = w_eq;
    assign o_stat.scan_end     = !r_q_vld && (r_idx >= r_count);
    assign o_stat.shift_done   = !r_q_vld && (r_idx == r_pos);
    assign o_result            = r_res;

    // Read port: forward scan, downward shift, or direct position read
    always_comb begin
        w_rd_en  = 1'b0;
        w_rd_idx = r_idx;
        if (i_cmd.search_step) begin
            w_rd_en = !w_stop && (r_idx < r_count);
        end else if (i_cmd.shift_step) begin
            w_rd_en  = (r_idx > r_pos);
            w_rd_idx = w_idx_dec;
        end else if (i_cmd.rd_key) begin
            w_rd_en  = 1'b1;
            w_rd_idx = r_key[CNT_W-1:0];
        end
    end

    // Write port: move an entry up one place, or store the new pair
    always_comb begin
        w_we    = 1'b0;
        w_wa    = w_q_inc[ADDR_W-1:0];
        w_wcol  = r_col_q;
        w_wcoef = r_coef_q;
        if (i_cmd.write_new) begin
            w_we    = 1'b1;
            w_wa    = r_pos[ADDR_W-1:0];
            w_wcol  = w_key_col;
            w_wcoef = r_coef;
        end else if (i_cmd.shift_step && r_q_vld) begin
            w_we = 1'b1;
        end
    end

    // Next control state
    always_comb begin
        n_count  = r_count;
        n_cursor = r_cursor;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_q_vld  = r_q_vld;
        if (i_cmd.search_init) begin
            n_idx   = i_cmd.from_cursor ? r_cursor : '0;
            n_q_vld = 1'b0;
        end
        if (i_cmd.search_step) begin
            n_idx   = w_rd_en ? w_idx_inc : r_idx;
            n_q_vld = w_rd_en;
        end
        if (i_cmd.shift_step) begin
            n_idx   = w_rd_en ? w_idx_dec : r_idx;
            n_q_vld = w_rd_en;
        end
        if (i_cmd.rd_key) begin
            n_q_vld = 1'b1;
        end
        if (i_cmd.shift_init) begin
            n_idx   = r_count;
            n_pos   = w_stop ? r_q_idx : r_count;
            n_q_vld = 1'b0;
        end
        if (i_cmd.cursor_upd && w_stop) begin
            n_cursor = w_eq ? w_q_inc : r_q_idx;
        end
        if (i_cmd.write_new) begin
            n_count = r_count + 1'b1;
        end
    end

    // Result build
    always_comb begin
        n_res            = r_res;
        n_res.value_out  = '0;
        n_res.column_out = '0;
        n_res.found      = 1'b0;
        n_res.status     = ST_QUERY;
        unique case (i_cmd.res_kind)
            RES_INSERTED:  n_res.status = ST_INSERTED;
            RES_DUPLICATE: n_res.status = ST_DUPLICATE;
            RES_ZERO:      n_res.status = ST_ZERO;
            RES_FULL:      n_res.status = ST_FULL;
            RES_LOOKUP: begin
                n_res.found     = w_eq;
                n_res.value_out = w_eq ? r_coef_q : '0;
            end
            RES_EXISTS:    n_res.found = w_eq;
            RES_POSITION: begin
                n_res.column_out = $signed({{(COL_OUT_W-COLUMN_BITS){1'b0}}, r_col_q});
            end
            RES_OUT_OF_RANGE: n_res.column_out = '1;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
            r_idx    <= '0;
            r_pos    <= '0;
            r_q_vld  <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_idx    <= n_idx;
            r_pos    <= n_pos;
            r_q_vld  <= n_q_vld;
        end
    end

    // Operand and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= i_key;
            r_coef <= i_coef;
        end
        if (i_cmd.set_res) begin
            r_res <= n_res;
        end
    end

    // Memories with registered read data
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_col_mem[w_wa]  <= w_wcol;
            r_coef_mem[w_wa] <= w_wcoef;
        end
        if (w_rd_en) begin
            r_col_q  <= r_col_mem[w_rd_addr];
            r_coef_q <= r_coef_mem[w_rd_addr];
            r_q_idx  <= w_rd_idx;
        end
    end

    `include "sorted_sparse_row_store_assert.svh"

    `SSRS_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY), "entry count above capacity")
    `SSRS_ASSERT_ALWAYS(a_cursor_bound, i_clk, i_rst_n, r_cursor <= r_count, "scan cursor beyond entry count")
    `SSRS_ASSERT_IMPLY(a_new_fits, i_clk, i_rst_n, i_cmd.write_new, !w_full && (r_pos <= r_count), "new entry written into full table or past count")
    `SSRS_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, i_cmd.write_new, r_count == $past(r_count) + 1'b1, "entry count did not advance by one")
    `SSRS_ASSERT_IMPLY(a_shift_ports, i_clk, i_rst_n, i_cmd.shift_step && r_q_vld && w_rd_en, w_wa != w_rd_addr, "shift read and write collide")

endmodule

// ===== rtl/ssrs_ctrl.sv =====
// Controller: state machine that sequences each operation through the datapath.
`timescale 1ns / 1ps
module ssrs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  ssrs_pkg::t_mode     i_mode,
    input  ssrs_pkg::t_dp_stat  i_stat,
    input  logic                i_obuf_ready,
    output logic                o_s_tready,
    output ssrs_pkg::t_ctrl_cmd o_cmd,
    output logic                o_push
);
    import ssrs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SEARCH,
        S_SHIFT,
        S_POS,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic   r_s_tready, n_s_tready;
    logic   w_accept;

    assign w_accept   = i_s_tvalid && r_s_tready;
    assign o_s_tready = r_s_tready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        o_cmd   = '0;
        o_push  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_mode     = i_mode;
                    n_state    = S_START;
                end
            end
            S_START: begin
                unique case (r_mode)
                    MODE_INSERT: begin
                        if (i_stat.zero_coef) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_kind = RES_ZERO;
                            n_state        = S_DONE;
                        end else begin
                            o_cmd.search_init = 1'b1;
                            n_state           = S_SEARCH;
                        end
                    end
                    MODE_LOOKUP: begin
                        o_cmd.search_init = 1'b1;
                        o_cmd.from_cursor = 1'b1;
                        n_state           = S_SEARCH;
                    end
                    MODE_POSITION: begin
                        if (i_stat.key_in_range) begin
                            o_cmd.rd_key = 1'b1;
                            n_state      = S_POS;
                        end else begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_kind = RES_OUT_OF_RANGE;
                            n_state        = S_DONE;
                        end
                    end
                    MODE_EXISTS: begin
                        o_cmd.search_init = 1'b1;
                        n_state           = S_SEARCH;
                    end
                endcase
            end
            S_SEARCH: begin
                if (i_stat.stop || i_stat.scan_end) begin
                    unique case (r_mode)
                        MODE_INSERT: begin
                            if (i_stat.eq) begin
                                o_cmd.set_res  = 1'b1;
                                o_cmd.res_kind = RES_DUPLICATE;
                                n_state        = S_DONE;
                            end else if (i_stat.table_full) begin
                                o_cmd.set_res  = 1'b1;
                                o_cmd.res_kind = RES_FULL;
                                n_state        = S_DONE;
                            end else begin
                                o_cmd.shift_init = 1'b1;
                                n_state          = S_SHIFT;
                            end
                        end
                        MODE_LOOKUP: begin
                            o_cmd.cursor_upd = 1'b1;
                            o_cmd.set_res    = 1'b1;
                            o_cmd.res_kind   = RES_LOOKUP;
                            n_state          = S_DONE;
                        end
                        MODE_EXISTS: begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_kind = RES_EXISTS;
                            n_state        = S_DONE;
                        end
                        MODE_POSITION: n_state = S_DONE;
                    endcase
                end else begin
                    o_cmd.search_step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_done) begin
                    o_cmd.write_new = 1'b1;
                    o_cmd.set_res   = 1'b1;
                    o_cmd.res_kind  = RES_INSERTED;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            S_POS: begin
                o_cmd.set_res  = 1'b1;
                o_cmd.res_kind = RES_POSITION;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_obuf_ready) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_s_tready = (n_state == S_IDLE);
    end

    // State and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode     <= MODE_INSERT;
            r_s_tready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_s_tready <= n_s_tready;
        end
    end

endmodule

// ===== rtl/ssrs_obuf.sv =====
// Output register: holds one result transaction for the master-side stream.
`timescale 1ns / 1ps
module ssrs_obuf (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  ssrs_pkg::t_result               i_result,
    input  logic                            i_m_tready,
    output logic                            o_ready,
    output logic                            o_m_tvalid,
    output logic [ssrs_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic [ssrs_pkg::M_TUSER_W-1:0]  o_m_tuser
);
    import ssrs_pkg::*;

    logic    r_valid, n_valid;
    t_result r_result;

    // Free when empty or draining this cycle
    assign o_ready    = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{(M_TDATA_W-COEF_W-COL_OUT_W){1'b0}},
                         r_result.column_out, r_result.value_out};
    assign o_m_tuser  = {r_result.status, r_result.found};

    always_comb begin
        n_valid = r_valid;
        if (i_push) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== rtl/sorted_sparse_row_store.sv =====
// Each item is loaded, then the row is scanned forward from the first entry or, for lookups,
// from the cursor. A stored insert then moves the entries above its place up and writes the
// new pair. Zero skips and out-of-range position reads skip the scan; in-range ones read
// the entry directly. One item at a time: the next is taken only after the last result is
// pushed into the output register, and the push waits while that register is held.
// Synchronous active-low reset empties the table, zeroes the cursor and drops any held result.
`timescale 1ns / 1ps
module sorted_sparse_row_store (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [ssrs_pkg::S_TDATA_W-1:0]  i_s_tdata,   // key[23:0], coefficient_in[87:24]
    input  logic [ssrs_pkg::S_TUSER_W-1:0]  i_s_tuser,   // mode[1:0]
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [ssrs_pkg::M_TDATA_W-1:0]  o_m_tdata,   // value_out[63:0], column_out[88:64], pad
    output logic [ssrs_pkg::M_TUSER_W-1:0]  o_m_tuser    // found[0], status[3:1]
);
    import ssrs_pkg::*;

    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;
    t_result   w_result;
    logic      w_push;
    logic      w_obuf_ready;
    t_mode     w_mode;

    assign w_mode = t_mode'(i_s_tuser);

    // Sequencer
    ssrs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_mode       (w_mode),
        .i_stat       (w_stat),
        .i_obuf_ready (w_obuf_ready),
        .o_s_tready   (o_s_tready),
        .o_cmd        (w_cmd),
        .o_push       (w_push)
    );

    // Table storage and compare logic
    ssrs_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (i_s_tdata[KEY_W-1:0]),
        .i_coef   (i_s_tdata[KEY_W+COEF_W-1:KEY_W]),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_result (w_result)
    );

    // Result transaction register
    ssrs_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_result   (w_result),
        .i_m_tready (i_m_tready),
        .o_ready    (w_obuf_ready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the sorted sparse row store: directed and random operations, table predictor.
module tb;
    import ssrs_pkg::*;

    localparam int                STALL_LIMIT   = 20000;
    localparam int                SETTLE_CYCLES = 2 * CAPACITY + 16;
    localparam int                RANDOM_ITEMS  = 540;
    localparam int                CALM_TAIL     = 60;
    localparam logic [COEF_W-1:0] NEG_ZERO      = 64'h8000_0000_0000_0000;
    localparam logic [KEY_W-1:0]  TOP_COLUMN    = '1;

    // Clock, reset and stream signals
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata  = '0;  // key[23:0], coefficient_in[87:24]
    logic [S_TUSER_W-1:0]  i_s_tuser  = '0;  // mode[1:0]
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;        // value_out[63:0], column_out[88:64], pad
    logic [M_TUSER_W-1:0]  o_m_tuser;        // found[0], status[3:1]

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    sorted_sparse_row_store u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Predicted row contents
    logic [KEY_W-1:0]  row_cols  [CAPACITY];
    logic [COEF_W-1:0] row_coefs [CAPACITY];
    int                row_count     = 0;
    int                lookup_cursor = 0;
    int                row_frontier  = 0;

    // Results still owed by the block, oldest first
    t_result due_results[$];

    int error_count  = 0;
    int items_sent   = 0;
    int results_seen = 0;
    bit send_calm    = 1'b1;
    bit final_phase  = 1'b0;

    // Result side bookkeeping
    int idle_cycles = 0;
    int rx_cycle    = 0;
    int stall_left  = 0;
    bit rx_calm     = 1'b1;

    task automatic report_error(string msg);
        $display("%0t ERROR: %s", $time, msg);
        error_count++;
    endtask

    function automatic bit row_has_column(logic [KEY_W-1:0] col);
        bit hit;
        hit = 1'b0;
        for (int i = 0; i < row_count; i++)
            if (row_cols[i] == col) hit = 1'b1;
        return hit;
    endfunction

    // Apply one operation to the predicted row and return the result it must give
    function automatic t_result apply_row_op(t_mode mode, logic [KEY_W-1:0] key,
                                             logic [COEF_W-1:0] coef);
        t_result res;
        int      pos;
        bit      done;
        res        = '0;
        res.status = ST_QUERY;
        done       = 1'b0;
        case (mode)
            MODE_INSERT: begin
                // both signed zeros are skipped; duplicate check wins over full
                if (coef[COEF_W-2:0] == '0) begin
                    res.status = ST_ZERO;
                end else if (row_has_column(key)) begin
                    res.status = ST_DUPLICATE;
                end else if (row_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    pos = row_count;
                    while (pos > 0 && row_cols[pos-1] > key) begin
                        row_cols[pos]  = row_cols[pos-1];
                        row_coefs[pos] = row_coefs[pos-1];
                        pos--;
                    end
                    row_cols[pos]  = key;
                    row_coefs[pos] = coef;
                    row_count++;
                    res.status = ST_INSERTED;
                end
            end
            MODE_LOOKUP: begin
                // forward scan from the cursor; above the last column it is a plain miss
                if (row_count > 0 && key <= row_cols[row_count-1]) begin
                    for (pos = lookup_cursor; pos < row_count && !done; pos++) begin
                        if (row_cols[pos] == key) begin
                            lookup_cursor = pos + 1;
                            res.value_out = row_coefs[pos];
                            res.found     = 1'b1;
                            done          = 1'b1;
                        end else if (row_cols[pos] > key) begin
                            lookup_cursor = pos;
                            done          = 1'b1;
                        end
                    end
                end
            end
            MODE_POSITION: begin
                if (key < row_count)
                    res.column_out = $signed({1'b0, row_cols[key]});
                else
                    res.column_out = -1;
            end
            default: begin
                res.found = row_has_column(key);
            end
        endcase
        return res;
    endfunction

    // Send one transaction and record the result it owes
    task automatic send_op(t_mode mode, logic [KEY_W-1:0] key, logic [COEF_W-1:0] coef);
        int gap;
        if (items_sent % 32 == 0)
            send_calm = final_phase || ($urandom_range(0, 3) == 0);
        if (!send_calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {coef, key};
        i_s_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_tready);
        due_results.push_back(apply_row_op(mode, key, coef));
        items_sent++;
    endtask

    // Hold off the sender until every owed result has come back
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    // Compare one accepted result with the oldest owed one
    task automatic check_result();
        t_result              want;
        logic [COEF_W-1:0]    got_value;
        logic [COL_OUT_W-1:0] got_col;
        logic                 got_found;
        logic [STATUS_W-1:0]  got_status;
        got_value  = o_m_tdata[COEF_W-1:0];
        got_col    = o_m_tdata[COEF_W +: COL_OUT_W];
        got_found  = o_m_tuser[0];
        got_status = o_m_tuser[1 +: STATUS_W];
        results_seen++;
        if (due_results.size() == 0) begin
            report_error($sformatf("result %0d with nothing owed: tdata=%h tuser=%h",
                                   results_seen, o_m_tdata, o_m_tuser));
        end else begin
            want = due_results.pop_front();
            if (got_value != want.value_out)
                report_error($sformatf("result %0d value_out %h, want %h",
                                       results_seen, got_value, want.value_out));
            if (got_col != want.column_out)
                report_error($sformatf("result %0d column_out %h, want %h",
                                       results_seen, got_col, want.column_out));
            if (got_found != want.found)
                report_error($sformatf("result %0d found %0d, want %0d",
                                       results_seen, got_found, want.found));
            if (got_status != want.status)
                report_error($sformatf("result %0d status %0d, want %0d",
                                       results_seen, got_status, want.status));
        end
    endtask

    // Result checking, watchdog and result-side stalls
    always @(posedge i_clk) begin
        if (i_rst_n && !((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** sorted_sparse_row_store: FAILED **");
            $finish;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready)
            check_result();
        if (rx_cycle % 128 == 0)
            rx_calm = final_phase || ($urandom_range(0, 3) == 0);
        rx_cycle++;
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Every query on a fresh, empty table
    task automatic test_empty_table();
        send_op(MODE_LOOKUP,   '0,         '0);
        send_op(MODE_EXISTS,   '0,         '0);
        send_op(MODE_POSITION, '0,         '0);
        send_op(MODE_POSITION, TOP_COLUMN, '0);
    endtask

    // Zero skipping, duplicates, sorted placement with shifts
    task automatic test_insert_rules();
        send_op(MODE_INSERT, 24'd100, '0);
        send_op(MODE_INSERT, 24'd100, NEG_ZERO);
        send_op(MODE_INSERT, 24'd100, 64'h3FF0_0000_0000_0000);
        send_op(MODE_INSERT, 24'd100, 64'h4000_0000_0000_0000);
        send_op(MODE_INSERT, 24'd0,   64'h7FF8_0000_0000_0000);
        send_op(MODE_INSERT, 24'd50,  64'hFFFF_FFFF_FFFF_FFFF);
        send_op(MODE_INSERT, 24'd7,   64'h0000_0000_0000_0001);
        send_op(MODE_INSERT, 24'd3,   64'h8000_0000_0000_0001);
    endtask

    // Positions, presence and the lookup cursor on the row 0, 3, 7, 50, 100
    task automatic test_queries();
        send_op(MODE_POSITION, 24'd0,  '0);
        send_op(MODE_POSITION, 24'd4,  '0);
        send_op(MODE_POSITION, 24'd5,  '0);
        send_op(MODE_EXISTS,   24'd50, '0);
        send_op(MODE_EXISTS,   24'd51, '0);
        send_op(MODE_LOOKUP,   24'd0,  '0);
        send_op(MODE_LOOKUP,   24'd2,  '0);    // miss, cursor parks on column 3
        send_op(MODE_LOOKUP,   24'd3,  '0);
        send_op(MODE_LOOKUP,   24'd60, '0);    // miss, cursor parks on column 100
        send_op(MODE_LOOKUP,   24'd7,  '0);    // out of order: stored but missed
        send_op(MODE_LOOKUP,   24'd200, '0);   // above the last column
        send_op(MODE_LOOKUP,   24'd100, '0);
        send_op(MODE_INSERT,   TOP_COLUMN, 64'h0000_0000_0000_0001);
        send_op(MODE_EXISTS,   TOP_COLUMN, '0);
        send_op(MODE_POSITION, 24'd5,  '0);
        row_frontier = 100;
    endtask

    // Rounds of ascending inserts and ordered lookups, mixed with random noise
    task automatic test_random_rows();
        int               stop_at;
        int               rounds;
        int               j;
        logic [KEY_W-1:0] col;
        logic [COEF_W-1:0] coef;
        t_mode            mode;
        stop_at = items_sent + RANDOM_ITEMS;
        rounds  = 0;
        while (items_sent < stop_at) begin
            rounds++;
            if (rounds == 20)
                wait_drained();
            // no idling on either side near the end of the run
            if (items_sent >= stop_at - CALM_TAIL) begin
                final_phase = 1'b1;
                send_calm   = 1'b1;
            end
            // new columns above the frontier, some zeros and duplicates
            repeat ($urandom_range(1, 4)) begin
                coef = {$urandom, $urandom};
                case ($urandom_range(0, 7))
                    0: begin
                        col  = KEY_W'(row_frontier + 1);
                        coef = $urandom_range(0, 1) ? NEG_ZERO : '0;
                    end
                    1: col = row_cols[$urandom_range(0, row_count - 1)];
                    default: begin
                        row_frontier += $urandom_range(1, 2048);
                        col = KEY_W'(row_frontier);
                    end
                endcase
                send_op(MODE_INSERT, col, coef);
            end
            // ordered lookups from the cursor, mostly hits, some near misses
            j = lookup_cursor;
            while (j < row_count - 1) begin
                if ($urandom_range(0, 3) == 0 && row_cols[j] != '0 &&
                    !row_has_column(row_cols[j] - 1'b1))
                    send_op(MODE_LOOKUP, row_cols[j] - 1'b1, '0);
                else
                    send_op(MODE_LOOKUP, row_cols[j], '0);
                j = lookup_cursor + $urandom_range(0, 2);
            end
            // noise over the whole field ranges
            repeat ($urandom_range(0, 3)) begin
                mode = t_mode'($urandom_range(0, 3));
                col  = KEY_W'($urandom);
                coef = {$urandom, $urandom};
                if (mode == MODE_POSITION && $urandom_range(0, 1))
                    col = KEY_W'($urandom_range(0, row_count));
                if (mode == MODE_EXISTS && $urandom_range(0, 1))
                    col = row_cols[$urandom_range(0, row_count - 1)];
                send_op(mode, col, coef);
            end
        end
    endtask

    // Edges of the grown row: zero and duplicate inserts, first and last positions, presence, lookups
    task automatic test_row_edges();
        final_phase = 1'b1;
        send_calm   = 1'b1;
        send_op(MODE_INSERT,   KEY_W'(row_frontier + 1), NEG_ZERO);
        send_op(MODE_INSERT,   row_cols[0],              64'h1);
        send_op(MODE_INSERT,   TOP_COLUMN,               64'h1);
        send_op(MODE_POSITION, KEY_W'(row_count - 1),    '0);
        send_op(MODE_POSITION, KEY_W'(row_count),        '0);
        send_op(MODE_POSITION, '0,                       '0);
        send_op(MODE_EXISTS,   row_cols[row_count - 1],  '0);
        send_op(MODE_EXISTS,   KEY_W'(row_frontier + 1), '0);
        if (lookup_cursor < row_count)
            send_op(MODE_LOOKUP, row_cols[lookup_cursor], '0);
        send_op(MODE_LOOKUP,   TOP_COLUMN,               '0);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_insert_rules();
        test_queries();
        wait_drained();
        test_random_rows();
        wait_drained();
        test_row_edges();
        i_s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("** sorted_sparse_row_store: PASSED **");
        else
            $display("** sorted_sparse_row_store: FAILED **");
        $finish;
    end

endmodule
